@@ sv/rgblab_pkg.sv @@
// Shared constants, widths and a helper function for the RGB to CIE Lab converter.
package rgblab_pkg;

    localparam int NUM_CH = 3;
    localparam int COMP_W = 8;
    localparam int COEF_W = 20;
    localparam int T_W    = 17;
    localparam int S_W    = 29;
    localparam int RCP_W  = 21;
    localparam int N_W    = 46;
    localparam int REM_W  = 31;
    localparam int F_W    = 17;

    typedef logic [T_W-1:0] t_q16;
    typedef logic [F_W-1:0] t_fval;

    // Matrix rows in millionths: X, Y, Z.
    localparam logic [COEF_W-1:0] COEF [NUM_CH][NUM_CH] = '{
        '{20'd412453, 20'd357580, 20'd180423},
        '{20'd212671, 20'd715160, 20'd72169},
        '{20'd19334,  20'd119193, 20'd950227}
    };

    // 255 times the white value in millionths, and its half.
    localparam logic [S_W-1:0] DEN_X = 29'd242366280;
    localparam logic [S_W-1:0] DEN_Y = 29'd255000000;
    localparam logic [S_W-1:0] DEN_Z = 29'd277632270;
    localparam logic [S_W-1:0] DEN [NUM_CH] = '{DEN_X, DEN_Y, DEN_Z};
    localparam logic [S_W-1:0] HALF [NUM_CH] = '{29'd121183140, 29'd127500000, 29'd138816135};

    // Reciprocals scaled by 2^48, so sum * RCP >> 32 approximates sum * 65536 / den.
    localparam logic [63:0] RCP_X64 = (64'd1 << 48) / 64'd242366280;
    localparam logic [63:0] RCP_Y64 = (64'd1 << 48) / 64'd255000000;
    localparam logic [63:0] RCP_Z64 = (64'd1 << 48) / 64'd277632270;
    localparam logic [RCP_W-1:0] RCP [NUM_CH] = '{
        RCP_X64[RCP_W-1:0], RCP_Y64[RCP_W-1:0], RCP_Z64[RCP_W-1:0]
    };

    // Threshold 0.008856 in Q1.16.
    localparam logic [T_W-1:0] THRESH = 17'd580;

    // Linear segment: (903292 * t + 1048634000) / 116000.
    localparam logic [19:0] LIN_MUL   = 20'd903292;
    localparam logic [30:0] LIN_ADD   = 31'd1048634000;
    localparam logic [30:0] LIN_DEN   = 31'd116000;
    localparam logic [63:0] LIN_RCP64 = (64'd1 << 48) / 64'd116000;
    localparam logic [31:0] LIN_RCP   = LIN_RCP64[31:0];

    localparam int CUBE_STAGES = T_W;
    localparam int LIN_STAGES  = 4;
    localparam int LIN_DLY     = CUBE_STAGES - LIN_STAGES;
    localparam int LAB_F_LAT   = CUBE_STAGES + 1;

    // Truncate a Q16 value toward zero and saturate to a signed byte.
    function automatic logic signed [7:0] trunc_sat_s8(input logic signed [27:0] v);
        logic        neg;
        logic [27:0] mag;
        logic [11:0] q;
        logic [7:0]  res;
        neg = v[27];
        mag = neg ? 28'(-v) : 28'(v);
        q   = mag[27:16];
        if (!neg && q > 12'd127) begin
            res = 8'd127;
        end else if (neg && q > 12'd128) begin
            res = 8'h80;
        end else if (neg) begin
            res = 8'(-q);
        end else begin
            res = q[7:0];
        end
        return $signed(res);
    endfunction

endpackage

@@ sv/rgblab_lab_f.sv @@
// Lab transfer function f(t): pipelined digit-by-digit cube root and linear segment.
module rgblab_lab_f (
    input  logic                i_clk,
    input  logic                i_en,
    input  rgblab_pkg::t_q16    i_t,
    output rgblab_pkg::t_fval   o_f
);
    import rgblab_pkg::*;

    logic [T_W-1:0] r_y  [CUBE_STAGES];
    logic [33:0]    r_y2 [CUBE_STAGES];
    logic [48:0]    r_y3 [CUBE_STAGES];
    logic [T_W-1:0] r_t  [CUBE_STAGES];

    // One result bit per stage, most significant first. y, y^2 and y^3 are kept
    // so that each trial cube is built from shifts and adds only.
    for (genvar j = 0; j < CUBE_STAGES; j++) begin : g_cube
        localparam int K = CUBE_STAGES - 1 - j;
        logic [T_W-1:0] y_in;
        logic [33:0]    y2_in;
        logic [48:0]    y3_in;
        logic [T_W-1:0] t_in;
        logic [52:0]    c2;
        logic [52:0]    c3;
        logic [52:0]    s2;
        logic [52:0]    s1;
        logic           take;

        if (j == 0) begin : g_first
            assign y_in  = '0;
            assign y2_in = '0;
            assign y3_in = '0;
            assign t_in  = i_t;
        end else begin : g_next
            assign y_in  = r_y[j-1];
            assign y2_in = r_y2[j-1];
            assign y3_in = r_y3[j-1];
            assign t_in  = r_t[j-1];
        end

        always_comb begin
            s2   = 53'(y2_in) << K;
            s1   = 53'(y_in) << (2 * K);
            c2   = 53'(y2_in) + (53'(y_in) << (K + 1)) + (53'd1 << (2 * K));
            c3   = 53'(y3_in) + s2 + (s2 << 1) + s1 + (s1 << 1) + (53'd1 << (3 * K));
            take = c3 <= 53'({t_in, 32'd0});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[j]  <= take ? (y_in | (T_W'(1) << K)) : y_in;
                r_y2[j] <= take ? c2[33:0] : y2_in;
                r_y3[j] <= take ? c3[48:0] : y3_in;
                r_t[j]  <= t_in;
            end
        end
    end

    // Linear segment: reciprocal multiply, then one remainder correction.
    logic [30:0] r_ln;
    logic [30:0] r_ln2;
    logic [14:0] r_lest;
    logic [14:0] r_lq;
    logic [17:0] r_lrem;
    logic [F_W-1:0] r_lf;
    logic [F_W-1:0] r_ld [LIN_DLY];
    logic [62:0] lin_prod;
    logic [30:0] lin_back;

    always_comb begin
        lin_prod = 63'(r_ln) * 63'(LIN_RCP);
        lin_back = 31'(r_lest) * LIN_DEN;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ln   <= 31'(LIN_MUL * 31'(i_t[9:0])) + LIN_ADD;
            r_ln2  <= r_ln;
            r_lest <= lin_prod[62:48];
            r_lq   <= r_lest;
            r_lrem <= 18'(r_ln2 - lin_back);
            r_lf   <= F_W'(r_lq) + ((31'(r_lrem) >= LIN_DEN) ? F_W'(1) : F_W'(0));
            r_ld[0] <= r_lf;
            for (int i = 1; i < LIN_DLY; i++) begin
                r_ld[i] <= r_ld[i-1];
            end
            o_f <= (r_t[CUBE_STAGES-1] > THRESH) ? r_y[CUBE_STAGES-1] : r_ld[LIN_DLY-1];
        end
    end

endmodule

@@ sv/rgb_to_cielab_pixel_unit.sv @@
// Top level of the RGB to CIE Lab (D65, no gamma) pixel converter.
//
// This block converts one 8-bit RGB pixel to CIE Lab in every clock cycle. A
// request enters a 23-stage pipeline: one stage forms the matrix row sums, three
// stages scale them to Q1.16 X, Y and Z through a reciprocal multiply and a
// remainder correction, seventeen stages take the cube root one result bit at a
// time while the linear segment is computed beside them, one stage selects the
// segment, and the last stage forms L, a and b into the output register. The
// sustained rate is one request per cycle while the output side does not stall.
// The whole pipeline advances together whenever the output register is empty
// or being taken; when the output side stalls with a result waiting, o_stall
// is raised and every stage holds its contents, so no request is lost or
// repeated. Results are bit exact to the fixed-point spec.
module rgb_to_cielab_pixel_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_lightness,
    output logic signed [7:0] o_green_red_axis,
    output logic signed [7:0] o_blue_yellow_axis
);
    import rgblab_pkg::*;

    localparam int PIPE = 4 + LAB_F_LAT + 1;

    logic            en;
    logic [PIPE-1:0] r_vld;
    logic [COMP_W-1:0] comp [NUM_CH];

    // The pipeline moves as one; it only holds when the finished request in the
    // output register cannot leave.
    assign en      = !r_vld[PIPE-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[PIPE-1];

    assign comp[0] = i_red;
    assign comp[1] = i_green;
    assign comp[2] = i_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE-2:0], i_valid};
        end
    end

    // Scaling to Q1.16: t = floor((S * 65536 + den / 2) / den). The reciprocal
    // estimate is never above the true quotient and at most two below it, so
    // one compare against den and 2 * den finishes the job.
    t_q16  r_t [NUM_CH];
    t_fval f   [NUM_CH];

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
        logic [S_W-1:0]   r_sum;
        logic [T_W-1:0]   r_est;
        logic [N_W-1:0]   r_num;
        logic [T_W-1:0]   r_q;
        logic [REM_W-1:0] r_rem;
        logic [S_W-1:0]   n_sum;
        logic [49:0]      prod;
        logic [N_W-1:0]   back;
        logic [T_W-1:0]   inc;

        always_comb begin
            n_sum = S_W'(COEF[ch][0]) * S_W'(comp[0])
                  + S_W'(COEF[ch][1]) * S_W'(comp[1])
                  + S_W'(COEF[ch][2]) * S_W'(comp[2]);
            prod  = 50'(r_sum) * 50'(RCP[ch]);
            back  = N_W'(r_est) * N_W'(DEN[ch]);
            if (r_rem >= (REM_W'(DEN[ch]) << 1)) begin
                inc = T_W'(2);
            end else if (r_rem >= REM_W'(DEN[ch])) begin
                inc = T_W'(1);
            end else begin
                inc = '0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sum     <= n_sum;
                r_est     <= prod[48:32];
                r_num     <= (N_W'(r_sum) << 16) + N_W'(HALF[ch]);
                r_q       <= r_est;
                r_rem     <= REM_W'(r_num - back);
                r_t[ch]   <= r_q + inc;
            end
        end

        rgblab_lab_f u_lab_f (
            .i_clk (i_clk),
            .i_en  (en),
            .i_t   (r_t[ch]),
            .o_f   (f[ch])
        );
    end

    // Lightness below the threshold is (9033 * Y + 327680) / 655360, done as a
    // shift by 17 and a divide by five on a value that stays below 43. It and
    // the threshold flag ride alongside the transfer-function pipeline.
    logic [23:0] llo_num;
    logic [10:0] llo_div;
    logic [6:0]  r_llo [LAB_F_LAT];
    logic        r_abv [LAB_F_LAT];

    always_comb begin
        llo_num = 24'(24'd9033 * 24'(r_t[1][9:0])) + 24'd327680;
        llo_div = 11'(llo_num[23:17]) * 11'd13;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_llo[0] <= 7'(llo_div[10:6]);
            r_abv[0] <= r_t[1] > THRESH;
            for (int i = 1; i < LAB_F_LAT; i++) begin
                r_llo[i] <= r_llo[i-1];
                r_abv[i] <= r_abv[i-1];
            end
        end
    end

    // Final stage: L = 116 fY - 16 or the linear lightness, a = 500 (fX - fY),
    // b = 200 (fY - fZ), in Q16 with one half added and truncated toward zero.
    logic [25:0]        l_v;
    logic [8:0]         l_q;
    logic [6:0]         n_l;
    logic signed [17:0] d_a;
    logic signed [17:0] d_b;
    logic signed [27:0] v_a;
    logic signed [27:0] v_b;

    always_comb begin
        l_v = 26'(f[1]) * 26'd116 - 26'd1015808;
        l_q = l_v[24:16];
        if (!r_abv[LAB_F_LAT-1]) begin
            n_l = r_llo[LAB_F_LAT-1];
        end else if (l_v[25]) begin
            n_l = '0;
        end else if (l_q > 9'd100) begin
            n_l = 7'd100;
        end else begin
            n_l = l_q[6:0];
        end
        d_a = $signed({1'b0, f[0]}) - $signed({1'b0, f[1]});
        d_b = $signed({1'b0, f[1]}) - $signed({1'b0, f[2]});
        v_a = 28'(d_a) * 28'sd500 + 28'sd32768;
        v_b = 28'(d_b) * 28'sd200 + 28'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_lightness        <= n_l;
            o_green_red_axis   <= trunc_sat_s8(v_a);
            o_blue_yellow_axis <= trunc_sat_s8(v_b);
        end
    end

endmodule
